/* hdl/isa_pkg.sv */
// Package with the operation codes, widths and pipeline sideband type of the stack ALU.
package isa_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned KindWidth  = 5;
  localparam int unsigned ShiftWidth = 8;

  typedef enum logic [KindWidth-1:0] {
    KindAshift = 5'd0,
    KindLshift = 5'd1,
    KindNot    = 5'd2,
    KindAbs    = 5'd3,
    KindNeg    = 5'd4,
    KindAdd    = 5'd5,
    KindSub    = 5'd6,
    KindMul    = 5'd7,
    KindDiv    = 5'd8,
    KindMod    = 5'd9,
    KindEq     = 5'd10,
    KindGt     = 5'd11,
    KindLt     = 5'd12,
    KindLe     = 5'd13,
    KindGe     = 5'd14,
    KindNe     = 5'd15,
    KindAnd    = 5'd16,
    KindOr     = 5'd17,
    KindXor    = 5'd18,
    KindMin    = 5'd19,
    KindMax    = 5'd20
  } kind_e;

  typedef struct packed {
    logic                 is_div;
    logic                 is_mod;
    logic                 neg_q;
    logic                 neg_r;
    logic                 dz;
    logic                 is_byte;
    logic                 handled;
    logic [DataWidth-1:0] res;
  } side_t;

endpackage

/* hdl/isa_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module isa_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [isa_pkg::DataWidth-1:0] num_i,
  input  logic [isa_pkg::DataWidth-1:0] den_i,
  input  isa_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [isa_pkg::DataWidth-1:0] quot_o,
  output logic [isa_pkg::DataWidth-1:0] rem_o,
  output isa_pkg::side_t                side_o
);

  localparam int unsigned W = isa_pkg::DataWidth;

  logic                 vld [1:W];
  logic [W-1:0]         rem [1:W];
  logic [W-1:0]         aq  [1:W];
  logic [W-1:0]         den [1:W];
  isa_pkg::side_t       side[1:W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic           vld_in;
    logic [W-1:0]   rem_in;
    logic [W-1:0]   aq_in;
    logic [W-1:0]   den_in;
    isa_pkg::side_t side_in;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign aq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld[s];
      assign rem_in  = rem[s];
      assign aq_in   = aq[s];
      assign den_in  = den[s];
      assign side_in = side[s];
    end

    assign trial = {rem_in, aq_in[W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign qbit  = ~diff[W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem[s+1]  <= qbit ? diff[W-1:0] : trial[W-1:0];
      aq[s+1]   <= {aq_in[W-2:0], qbit};
      den[s+1]  <= den_in;
      side[s+1] <= side_in;
    end
  end

  assign valid_o = vld[W];
  assign quot_o  = aq[W];
  assign rem_o   = rem[W];
  assign side_o  = side[W];

endmodule

/* hdl/int32_stack_alu_unit.sv */
// Top level of the pipelined 32-bit stack machine ALU.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  command | start, kind_i, lhs_i, rhs_i, shift_count_i; busy out | in
//  result  | valid_o, result_o, result_is_byte_o, handled_o,      | out
//          | divide_by_zero_o                                     |
//
// A transfer is taken in every cycle; busy is always low.
// Each operation passes one operand stage, 32 divider stages and one output stage.
// The divider pipeline sets the latency; every operation travels through it.
// Reset clears only the valid bits. The receiver cannot stall the results.
module int32_stack_alu_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [isa_pkg::KindWidth-1:0]   kind_i,
  input  logic signed [isa_pkg::DataWidth-1:0]  lhs_i,
  input  logic signed [isa_pkg::DataWidth-1:0]  rhs_i,
  input  logic signed [isa_pkg::ShiftWidth-1:0] shift_count_i,
  output logic                            valid_o,
  output logic signed [isa_pkg::DataWidth-1:0]  result_o,
  output logic                            result_is_byte_o,
  output logic                            handled_o,
  output logic                            divide_by_zero_o
);

  localparam int unsigned W  = isa_pkg::DataWidth;
  localparam int unsigned SW = isa_pkg::ShiftWidth;

  logic           in_vld_q;
  logic [W-1:0]   num_q, den_q;
  isa_pkg::side_t side_d, side_q;
  logic [W-1:0]   abs_a, abs_b;
  logic           slt_ab, slt_ba;
  logic [isa_pkg::ShiftWidth-1:0] mag;
  logic [W-1:0]   shl, sar;
  logic           div_vld;
  logic [W-1:0]   quot, rem;
  isa_pkg::side_t side_o;
  logic [W-1:0]   res_d, res_q;
  logic           vld_q, byte_q, hand_q, dz_q;

  assign busy  = 1'b0;
  assign abs_a = lhs_i[W-1] ? (~lhs_i + W'(1)) : lhs_i;
  assign abs_b = rhs_i[W-1] ? (~rhs_i + W'(1)) : rhs_i;
  assign slt_ab = lhs_i < rhs_i;
  assign slt_ba = rhs_i < lhs_i;
  assign mag = ~shift_count_i + SW'(1);
  assign shl = (shift_count_i >= 8'sd32) ? '0 : (lhs_i << shift_count_i[4:0]);
  assign sar = (mag >= 8'd32) ? {W{lhs_i[W-1]}} : W'(lhs_i >>> mag[4:0]);

  always_comb begin
    side_d         = '0;
    side_d.handled = 1'b1;
    unique case (kind_i)
      isa_pkg::KindAshift,
      isa_pkg::KindLshift: side_d.res = shift_count_i[7] ? sar : shl;
      isa_pkg::KindNot:    side_d.res = ~lhs_i;
      isa_pkg::KindAbs:    side_d.res = abs_a;
      isa_pkg::KindNeg:    side_d.res = ~lhs_i + W'(1);
      isa_pkg::KindAdd:    side_d.res = lhs_i + rhs_i;
      isa_pkg::KindSub:    side_d.res = lhs_i - rhs_i;
      isa_pkg::KindMul:    side_d.res = W'(lhs_i * rhs_i);
      isa_pkg::KindDiv, isa_pkg::KindMod: begin
        side_d.is_div = (kind_i == isa_pkg::KindDiv);
        side_d.is_mod = (kind_i == isa_pkg::KindMod);
        side_d.neg_q  = lhs_i[W-1] ^ rhs_i[W-1];
        side_d.neg_r  = lhs_i[W-1];
        side_d.dz     = (rhs_i == '0);
      end
      isa_pkg::KindEq: begin side_d.res = W'(lhs_i == rhs_i); side_d.is_byte = 1'b1; end
      isa_pkg::KindGt: begin side_d.res = W'(slt_ba);         side_d.is_byte = 1'b1; end
      isa_pkg::KindLt: begin side_d.res = W'(slt_ab);         side_d.is_byte = 1'b1; end
      isa_pkg::KindLe: begin side_d.res = W'(!slt_ba);        side_d.is_byte = 1'b1; end
      isa_pkg::KindGe: begin side_d.res = W'(!slt_ab);        side_d.is_byte = 1'b1; end
      isa_pkg::KindNe: begin side_d.res = W'(lhs_i != rhs_i); side_d.is_byte = 1'b1; end
      isa_pkg::KindAnd:    side_d.res = lhs_i & rhs_i;
      isa_pkg::KindOr:     side_d.res = lhs_i | rhs_i;
      isa_pkg::KindXor:    side_d.res = lhs_i ^ rhs_i;
      isa_pkg::KindMin:    side_d.res = slt_ab ? lhs_i : rhs_i;
      isa_pkg::KindMax:    side_d.res = slt_ab ? rhs_i : lhs_i;
      default:             side_d.handled = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= abs_a;
    den_q  <= abs_b;
    side_q <= side_d;
  end

  isa_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (div_vld),
    .quot_o  (quot),
    .rem_o   (rem),
    .side_o  (side_o)
  );

  always_comb begin
    priority if (side_o.dz) begin
      res_d = '0;
    end else if (side_o.is_div) begin
      res_d = side_o.neg_q ? (~quot + W'(1)) : quot;
    end else if (side_o.is_mod) begin
      res_d = side_o.neg_r ? (~rem + W'(1)) : rem;
    end else begin
      res_d = side_o.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    byte_q <= side_o.is_byte;
    hand_q <= side_o.handled;
    dz_q   <= side_o.dz;
  end

  assign valid_o          = vld_q;
  assign result_o         = res_q;
  assign result_is_byte_o = byte_q;
  assign handled_o        = hand_q;
  assign divide_by_zero_o = dz_q;

endmodule

/* sim/int32_stack_alu_checker.sv */
// Checker that predicts and compares every result transfer of the stack ALU.
`timescale 1ns / 100ps
module int32_stack_alu_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [isa_pkg::KindWidth-1:0]         kind_i,
  input  logic signed [isa_pkg::DataWidth-1:0]  lhs_i,
  input  logic signed [isa_pkg::DataWidth-1:0]  rhs_i,
  input  logic signed [isa_pkg::ShiftWidth-1:0] shift_count_i,
  input  logic                                  valid_o,
  input  logic signed [isa_pkg::DataWidth-1:0]  result_o,
  input  logic                                  result_is_byte_o,
  input  logic                                  handled_o,
  input  logic                                  divide_by_zero_o,
  output int                                    fail_count,
  output int                                    pending_count
);

  typedef struct packed {
    logic [isa_pkg::DataWidth-1:0] res;
    logic                          is_byte;
    logic                          handled;
    logic                          dz;
  } alu_out_t;

  alu_out_t pending_q[$];

  function automatic logic [31:0] twos_neg(logic [31:0] x);
    return ~x + 32'd1;
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? twos_neg(x) : x;
  endfunction

  function automatic alu_out_t compute_alu(logic [4:0] k, logic [31:0] a, logic [31:0] b,
                                           logic [7:0] sc);
    alu_out_t o;
    logic signed [31:0] sa, sb;
    logic [31:0] q, r;
    int unsigned n;
    sa = a;
    sb = b;
    o = '0;
    o.handled = 1'b1;
    case (k)
      isa_pkg::KindAshift, isa_pkg::KindLshift: begin
        if (sc[7]) begin
          n = 256 - sc;
          if (n >= 32) o.res = {32{a[31]}};
          else o.res = sa >>> n;
        end else begin
          o.res = (sc >= 32) ? 32'd0 : (a << sc);
        end
      end
      isa_pkg::KindNot: o.res = ~a;
      isa_pkg::KindAbs: o.res = magnitude(a);
      isa_pkg::KindNeg: o.res = twos_neg(a);
      isa_pkg::KindAdd: o.res = a + b;
      isa_pkg::KindSub: o.res = a - b;
      isa_pkg::KindMul: o.res = a * b;
      isa_pkg::KindDiv, isa_pkg::KindMod: begin
        if (b == 32'd0) begin
          o.dz = 1'b1;
        end else begin
          q = magnitude(a) / magnitude(b);
          r = magnitude(a) % magnitude(b);
          if (k == isa_pkg::KindDiv) o.res = (a[31] ^ b[31]) ? twos_neg(q) : q;
          else o.res = a[31] ? twos_neg(r) : r;
        end
      end
      isa_pkg::KindEq: begin o.res = (a == b); o.is_byte = 1'b1; end
      isa_pkg::KindGt: begin o.res = (sa > sb); o.is_byte = 1'b1; end
      isa_pkg::KindLt: begin o.res = (sa < sb); o.is_byte = 1'b1; end
      isa_pkg::KindLe: begin o.res = (sa <= sb); o.is_byte = 1'b1; end
      isa_pkg::KindGe: begin o.res = (sa >= sb); o.is_byte = 1'b1; end
      isa_pkg::KindNe: begin o.res = (a != b); o.is_byte = 1'b1; end
      isa_pkg::KindAnd: o.res = a & b;
      isa_pkg::KindOr:  o.res = a | b;
      isa_pkg::KindXor: o.res = a ^ b;
      isa_pkg::KindMin: o.res = (sa < sb) ? a : b;
      isa_pkg::KindMax: o.res = (sa < sb) ? b : a;
      default: o.handled = 1'b0;
    endcase
    return o;
  endfunction

  assign pending_count = pending_q.size();

  initial fail_count = 0;

  always @(posedge clk_i) begin
    alu_out_t exp_r, got;
    if (rst_ni) begin
      if (valid_o) begin
        got = '{result_o, result_is_byte_o, handled_o, divide_by_zero_o};
        if (pending_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result transfer: %h", got);
        end else begin
          exp_r = pending_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: res %h/%h byte %b/%b handled %b/%b dz %b/%b",
                       exp_r.res, got.res, exp_r.is_byte, got.is_byte,
                       exp_r.handled, got.handled, exp_r.dz, got.dz);
          end
        end
      end
      if (start && !busy)
        pending_q.push_back(compute_alu(kind_i, lhs_i, rhs_i, shift_count_i));
    end
  end
endmodule

/* sim/tb_int32_stack_alu_unit.sv */
// Testbench top that drives operations into the stack ALU and reports the verdict.
`timescale 1ns / 100ps
module tb_int32_stack_alu_unit;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [isa_pkg::KindWidth-1:0] kind_i = '0;
  logic signed [isa_pkg::DataWidth-1:0] lhs_i = '0;
  logic signed [isa_pkg::DataWidth-1:0] rhs_i = '0;
  logic signed [isa_pkg::ShiftWidth-1:0] shift_count_i = '0;
  logic valid_o;
  logic signed [isa_pkg::DataWidth-1:0] result_o;
  logic result_is_byte_o, handled_o, divide_by_zero_o;
  int fail_count, pending_count;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int32_stack_alu_unit dut (.*);
  int32_stack_alu_checker u_checker (.*);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(logic [4:0] k, logic [31:0] a, logic [31:0] b, logic [7:0] sc);
    start <= 1'b1;
    kind_i <= k;
    lhs_i <= a;
    rhs_i <= b;
    shift_count_i <= sc;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  initial begin
    logic [4:0] k;
    logic [31:0] a;
    logic [31:0] b;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    issue_op(isa_pkg::KindAshift, 32'h8000_0001, 0, 8'd0);
    issue_op(isa_pkg::KindLshift, 32'h1234_5678, 0, 8'd31);
    issue_op(isa_pkg::KindAshift, 32'hffff_ffff, 0, 8'd32);
    issue_op(isa_pkg::KindLshift, 32'h8000_0000, 0, 8'h81);
    issue_op(isa_pkg::KindAshift, 32'h8000_0000, 0, 8'hff);
    issue_op(isa_pkg::KindAshift, 32'h7fff_ffff, 0, 8'd127);
    issue_op(isa_pkg::KindAbs, 32'h8000_0000, 0, 0);
    issue_op(isa_pkg::KindNeg, 32'h8000_0000, 0, 0);
    issue_op(isa_pkg::KindNot, 32'h0, 0, 0);
    issue_op(isa_pkg::KindDiv, 32'h8000_0000, 32'hffff_ffff, 0);
    issue_op(isa_pkg::KindMod, 32'h8000_0000, 32'hffff_ffff, 0);
    issue_op(isa_pkg::KindDiv, 32'hffff_fff9, 32'd2, 0);
    issue_op(isa_pkg::KindMod, 32'hffff_fff9, 32'd2, 0);
    issue_op(isa_pkg::KindDiv, 32'd5, 32'd0, 0);
    issue_op(isa_pkg::KindMod, 32'd5, 32'd0, 0);
    issue_op(isa_pkg::KindMul, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    issue_op(isa_pkg::KindAdd, 32'h7fff_ffff, 32'd1, 0);
    issue_op(isa_pkg::KindSub, 32'h8000_0000, 32'd1, 0);
    issue_op(isa_pkg::KindLt, 32'h8000_0000, 32'h7fff_ffff, 0);
    issue_op(isa_pkg::KindGe, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    issue_op(isa_pkg::KindMin, 32'h8000_0000, 32'd3, 0);
    issue_op(isa_pkg::KindMax, 32'h8000_0000, 32'd3, 0);
    issue_op(5'd21, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    issue_op(5'd31, 32'd1, 32'd1, 0);
    pause_cycles(1);
    while (pending_count != 0) @(negedge clk_i);
    for (int i = 0; i < 1450; i++) begin
      if (i < 1300 && $urandom_range(0, 9) == 0) pause_cycles($urandom_range(1, 6));
      if (i == 700) begin
        pause_cycles(1);
        while (pending_count != 0) @(negedge clk_i);
      end
      k = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
      a = pick_operand();
      b = pick_operand();
      if ((k == isa_pkg::KindEq || k == isa_pkg::KindNe) && $urandom_range(0, 1)) b = a;
      issue_op(k, a, b, 8'($urandom));
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
hdl/isa_pkg.sv
hdl/isa_div_pipe.sv
hdl/int32_stack_alu_unit.sv
sim/int32_stack_alu_checker.sv
sim/tb_int32_stack_alu_unit.sv
